[hw/rtl/wed_pkg.sv]
package wed_pkg;

  localparam int unsigned MaxDims  = 8;
  localparam int unsigned DimCntW  = $clog2(MaxDims + 1);
  localparam int unsigned DimSlots = 8;
  localparam int unsigned DimIdxW  = $clog2(DimSlots);

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SpanW  = 32;
  localparam int unsigned SumW   = 2 * CoordW;
  localparam int unsigned RootW  = SumW / 2;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned SqrtStepW = $clog2(RootW);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WRAP_MASK = 3'd0,
    REG_SPAN_01   = 3'd1,
    REG_SPAN_23   = 3'd2,
    REG_SPAN_45   = 3'd3,
    REG_SPAN_67   = 3'd4
  } cfg_reg_e;

  // One classified dimension on its way to the back end
  typedef struct packed {
    logic [DiffW-1:0] diff;
    logic [SpanW-1:0] diam;
    logic             fold_en;
    logic             use_dim;
    logic             last;
  } wed_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_MUL,
    S_ACC,
    S_SQRT,
    S_DONE
  } back_state_e;

endpackage

[hw/rtl/wrapped_euclidean_distance.sv]
// A dimension item enters the queue when it is accepted and leaves it once the back end
// is idle; it then goes through the load, fold, square and add steps. The last item of
// a vector adds 32 square-root steps and an output load, which presents its distance.
// The shared square/add datapath takes no new item until done with the last one; the
// 4-entry queue lets input transactions run ahead. Reset clears the sum, flags, counter,
// configuration and queue at once.
module wrapped_euclidean_distance (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wed_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // coord_a, coord_b
  input  logic                         s_axis_tlast,  // last_dim
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // dist_value
  output logic [1:0]                   m_axis_tuser   // saturated, dim_overflow
);
  import wed_pkg::*;

  wed_entry_t push_entry, head_entry;
  logic       push, q_full, q_valid, pop;
  logic       sat, ovf;

  wed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .coord_a_i   (s_axis_tdata[CoordW-1:0]),
    .coord_b_i   (s_axis_tdata[2*CoordW-1:CoordW]),
    .last_dim_i  (s_axis_tlast),
    .push_o      (push),
    .entry_o     (push_entry),
    .q_full_i    (q_full)
  );

  wed_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  wed_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .dist_value_o   (m_axis_tdata),
    .saturated_o    (sat),
    .dim_overflow_o (ovf)
  );

  assign m_axis_tuser = {ovf, sat};

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("queue written while full");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue read while empty");

  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !pop) |=> q_full)
    else $error("queue lost an entry without a read");
`endif

endmodule

[hw/rtl/wed_front.sv]
module wed_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wed_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wed_pkg::CoordW-1:0]   coord_a_i,
  input  logic [wed_pkg::CoordW-1:0]   coord_b_i,
  input  logic                         last_dim_i,
  output logic                         push_o,
  output wed_pkg::wed_entry_t          entry_o,
  input  logic                         q_full_i
);
  import wed_pkg::*;

  logic [DimSlots-1:0] wrap_mask_q;
  logic [CfgDataW-1:0] span_q [DimSlots/2];
  logic [DimCntW-1:0]  dim_q, dim_d;
  logic [DimIdxW-1:0]  idx;
  logic                over;
  logic [CfgDataW-1:0] span_pair;
  logic                accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign push_o      = accept;

  assign over      = (dim_q == DimCntW'(MaxDims));
  assign idx       = dim_q[DimIdxW-1:0];
  assign span_pair = span_q[idx[DimIdxW-1:1]];

  always_comb begin
    entry_o.diff    = {coord_a_i[CoordW-1], coord_a_i} - {coord_b_i[CoordW-1], coord_b_i};
    entry_o.diam    = idx[0] ? span_pair[CfgDataW-1:SpanW] : span_pair[SpanW-1:0];
    entry_o.fold_en = wrap_mask_q[idx];
    entry_o.use_dim = !over;
    entry_o.last    = last_dim_i;
  end

  always_comb begin
    dim_d = dim_q;
    if (accept) begin
      if (last_dim_i) begin
        dim_d = '0;
      end else if (!over) begin
        dim_d = dim_q + DimCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= '0;
    end else begin
      dim_q <= dim_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_mask_q <= '0;
      for (int i = 0; i < DimSlots / 2; i++) begin
        span_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WRAP_MASK: wrap_mask_q <= cfg_data_i[DimSlots-1:0];
        REG_SPAN_01:   span_q[0] <= cfg_data_i;
        REG_SPAN_23:   span_q[1] <= cfg_data_i;
        REG_SPAN_45:   span_q[2] <= cfg_data_i;
        REG_SPAN_67:   span_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/wed_fifo.sv]
module wed_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wed_pkg::wed_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output wed_pkg::wed_entry_t entry_o
);
  import wed_pkg::*;

  wed_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= rd_q + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/wed_back.sv]
module wed_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  wed_pkg::wed_entry_t       entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [wed_pkg::RootW-1:0] dist_value_o,
  output logic                      saturated_o,
  output logic                      dim_overflow_o
);
  import wed_pkg::*;

  back_state_e state_q, state_d;

  logic [CoordW-1:0] mag_q, abs_mag, fold_mag;
  logic [SpanW-1:0]  diam_q;
  logic              fold_q, use_q, last_q;
  logic [SumW-1:0]   prod_q;
  logic [SumW-1:0]   sum_q, sum_nxt;
  logic              sat_q, sat_nxt, over_q;
  logic [SumW:0]     sum_ext;
  logic              do_fold;

  logic [SumW-1:0]      rad_q;
  logic [RemW-1:0]      rem_q;
  logic [RootW-1:0]     root_q;
  logic [SqrtStepW-1:0] step_q;
  logic [RemW+1:0]      rem_t, trial;
  logic                 ge;

  logic out_valid_q;
  logic out_load, load_op;

  // Magnitude of a 33-bit difference of two 32-bit values always fits 32 bits
  assign abs_mag = entry_i.diff[DiffW-1] ? CoordW'(-entry_i.diff) : entry_i.diff[CoordW-1:0];

  assign do_fold  = fold_q && ({1'b0, mag_q, 1'b0} > {2'b00, diam_q});
  assign fold_mag = (diam_q >= mag_q) ? (diam_q - mag_q) : (mag_q - diam_q);

  assign sum_ext = {1'b0, sum_q} + {1'b0, prod_q};
  always_comb begin
    sum_nxt = sum_q;
    sat_nxt = sat_q;
    if (use_q) begin
      if (sum_ext[SumW]) begin
        sum_nxt = '1;
        sat_nxt = 1'b1;
      end else begin
        sum_nxt = sum_ext[SumW-1:0];
        if (&sum_ext[SumW-1:0]) sat_nxt = 1'b1;
      end
    end
  end

  // Restoring square root, one result bit per step
  assign rem_t = {rem_q, rad_q[SumW-1:SumW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = (rem_t >= trial);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (q_valid_i) state_d = S_FOLD;
      S_FOLD: state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = last_q ? S_SQRT : S_IDLE;
      S_SQRT: if (step_q == '1) state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    load_op  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE:  load_op  = q_valid_i;
      S_DONE:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign pop_o = load_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ACC) begin
        sum_q <= sum_nxt;
        sat_q <= sat_nxt;
        if (!use_q) over_q <= 1'b1;
      end
      if (out_load) begin
        sum_q  <= '0;
        sat_q  <= 1'b0;
        over_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_op) begin
      mag_q  <= abs_mag;
      diam_q <= entry_i.diam;
      fold_q <= entry_i.fold_en;
      use_q  <= entry_i.use_dim;
      last_q <= entry_i.last;
    end
    if (state_q == S_FOLD && do_fold) mag_q <= fold_mag;
    if (state_q == S_MUL) prod_q <= mag_q * mag_q;
    if (state_q == S_ACC) begin
      rad_q  <= sum_nxt;
      rem_q  <= '0;
      root_q <= '0;
      step_q <= '0;
    end
    if (state_q == S_SQRT) begin
      rad_q  <= {rad_q[SumW-3:0], 2'b00};
      rem_q  <= ge ? RemW'(rem_t - trial) : RemW'(rem_t);
      root_q <= {root_q[RootW-2:0], ge};
      step_q <= step_q + SqrtStepW'(1);
    end
    if (out_load) begin
      dist_value_o   <= root_q;
      saturated_o    <= sat_q;
      dim_overflow_o <= over_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
